FILE: src/lkvc_pkg.sv
`timescale 1ns / 1ps

package lkvc_pkg;

    localparam int ENTRIES_DEFAULT = 8;
    localparam int DATA_W          = 32;
    localparam int CFG_W           = 4;

    localparam logic [CFG_W-1:0]  CAPACITY_RESET = 4'd8;
    localparam logic [DATA_W-1:0] MISS_VALUE     = '1;

    typedef enum logic
    {
        CMD_SET = 1'b0,
        CMD_GET = 1'b1
    } command_t;

endpackage

FILE: src/lkvc_lookup.sv
`timescale 1ns / 1ps

module lkvc_lookup #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT,
    parameter int RANK_W  = 3
) (
    input  logic [ENTRIES-1:0]                entry_valid,
    input  logic [lkvc_pkg::DATA_W-1:0]       entry_key [ENTRIES],
    input  logic [lkvc_pkg::DATA_W-1:0]       entry_value [ENTRIES],
    input  logic [RANK_W-1:0]                 entry_rank [ENTRIES],
    input  logic [lkvc_pkg::DATA_W-1:0]       search_key,
    output logic [ENTRIES-1:0]                match,
    output logic [RANK_W-1:0]                 match_rank,
    output logic [lkvc_pkg::DATA_W-1:0]       match_value
);

    // valid keys are unique, so at most one match bit is set and an or-merge selects it
    always_comb
    begin
        match_rank  = '0;
        match_value = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i]    = entry_valid[i] && (entry_key[i] == search_key);
            match_rank  = match_rank  | (entry_rank[i]  & {RANK_W{match[i]}});
            match_value = match_value | (entry_value[i] & {lkvc_pkg::DATA_W{match[i]}});
        end
    end

endmodule

FILE: src/lru_key_value_cache_core.sv
`timescale 1ns / 1ps
// fully associative key-value cache with least-recently-used replacement
// request channel: in_valid/in_ready with command, lookup_key, write_value;
//   command set stores write_value under lookup_key, get looks the key up
// result channel: out_valid/out_ready with hit and read_value, one result per get;
//   a miss returns hit low and read_value all ones, a set returns nothing
// config channel: cfg_valid/cfg_ready with capacity_in_use, always ready;
//   write it only while no request is in flight. 0 acts as 1, above ENTRIES as ENTRIES
// order: a request is registered on acceptance and handled from the request register;
//   out_valid for a get rises when its result loads into the result register
// throughput: one request per cycle unless a get waits on a full result register;
//   the key compare over all entries, the rank update and the free-slot search
//   all sit between the request register and the state and result registers
// receiver stall: the result register holds its result while out_ready is low;
//   a waiting get then holds the request register, and in_ready drops; sets
//   keep flowing until a get meets the full result register
// reset: all entries invalid, occupancy zero, capacity 8, no result pending

module lru_key_value_cache_core #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lkvc_pkg::CFG_W-1:0]          capacity_in_use,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                command,
    input  logic signed [lkvc_pkg::DATA_W-1:0]  lookup_key,
    input  logic signed [lkvc_pkg::DATA_W-1:0]  write_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output logic signed [lkvc_pkg::DATA_W-1:0]  read_value
);

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (OCC_W > lkvc_pkg::CFG_W) ? OCC_W : lkvc_pkg::CFG_W;

    logic [lkvc_pkg::CFG_W-1:0]   capacity_reg;

    logic                         req_valid_reg;
    lkvc_pkg::command_t           req_cmd_reg;
    logic [lkvc_pkg::DATA_W-1:0]  req_key_reg;
    logic [lkvc_pkg::DATA_W-1:0]  req_value_reg;

    logic                         out_valid_reg;
    logic                         hit_reg;
    logic [lkvc_pkg::DATA_W-1:0]  read_value_reg;

    logic [ENTRIES-1:0]           valid_reg;
    logic [ENTRIES-1:0]           valid_next;
    logic [RANK_W-1:0]            rank_reg  [ENTRIES];
    logic [RANK_W-1:0]            rank_next [ENTRIES];
    logic [OCC_W-1:0]             occ_reg;
    logic [OCC_W-1:0]             occ_next;
    logic [lkvc_pkg::DATA_W-1:0]  key_reg   [ENTRIES];
    logic [lkvc_pkg::DATA_W-1:0]  value_reg [ENTRIES];

    logic [ENTRIES-1:0]           match;
    logic [RANK_W-1:0]            match_rank;
    logic [lkvc_pkg::DATA_W-1:0]  match_value;
    logic                         lookup_hit;

    logic                         proc_fire;
    logic [OCC_W-1:0]             cap_eff;
    logic [CMP_W-1:0]             cap_ext;
    logic                         full;
    logic [ENTRIES-1:0]           kept;
    logic [RANK_W-1:0]            free_idx;
    logic [ENTRIES-1:0]           key_we;
    logic [ENTRIES-1:0]           value_we;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= lkvc_pkg::CAPACITY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            capacity_reg <= capacity_in_use;
        end
    end

    lkvc_lookup #(
        .ENTRIES (ENTRIES),
        .RANK_W  (RANK_W)
    ) u_lookup (
        .entry_valid (valid_reg),
        .entry_key   (key_reg),
        .entry_value (value_reg),
        .entry_rank  (rank_reg),
        .search_key  (req_key_reg),
        .match       (match),
        .match_rank  (match_rank),
        .match_value (match_value)
    );

    assign lookup_hit = |match;

    // a set never waits; a get waits only for room in the result register
    assign proc_fire = req_valid_reg &&
                       ((req_cmd_reg == lkvc_pkg::CMD_SET) || !out_valid_reg || out_ready);
    assign in_ready  = !req_valid_reg || proc_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            req_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_cmd_reg   <= lkvc_pkg::command_t'(command);
            req_key_reg   <= lookup_key;
            req_value_reg <= write_value;
        end
    end

    always_comb
    begin
        cap_ext = CMP_W'(capacity_reg);
        if (capacity_reg == '0)
        begin
            cap_eff = OCC_W'(1);
        end
        else if (cap_ext > CMP_W'(ENTRIES))
        begin
            cap_eff = OCC_W'(ENTRIES);
        end
        else
        begin
            cap_eff = OCC_W'(cap_ext);
        end
    end

    assign full = (occ_reg >= cap_eff);

    // when full, drop every entry ranked at or below the last slot of the capacity
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            kept[i] = valid_reg[i] && !(full && (OCC_W'(rank_reg[i]) >= (cap_eff - OCC_W'(1))));
        end
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!kept[i])
            begin
                free_idx = RANK_W'(i);
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        occ_next   = occ_reg;
        key_we     = '0;
        value_we   = '0;
        if (proc_fire)
        begin
            if (lookup_hit)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (match[i])
                    begin
                        rank_next[i] = '0;
                    end
                    else if (valid_reg[i] && (rank_reg[i] < match_rank))
                    begin
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                end
                if (req_cmd_reg == lkvc_pkg::CMD_SET)
                begin
                    value_we = match;
                end
            end
            else if (req_cmd_reg == lkvc_pkg::CMD_SET)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (kept[i])
                    begin
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                    else
                    begin
                        rank_next[i] = '0;
                    end
                end
                valid_next           = kept;
                valid_next[free_idx] = 1'b1;
                key_we[free_idx]     = 1'b1;
                value_we[free_idx]   = 1'b1;
                // eviction always leaves exactly capacity minus one behind
                occ_next = full ? cap_eff : (occ_reg + OCC_W'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (key_we[i])
            begin
                key_reg[i] <= req_key_reg;
            end
            if (value_we[i])
            begin
                value_reg[i] <= req_value_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_fire && (req_cmd_reg == lkvc_pkg::CMD_GET))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && (req_cmd_reg == lkvc_pkg::CMD_GET))
        begin
            hit_reg        <= lookup_hit;
            read_value_reg <= lookup_hit ? match_value : lkvc_pkg::MISS_VALUE;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign read_value = read_value_reg;

endmodule

FILE: src/lkvc_checker.sv
`timescale 1ns / 1ps

module lkvc_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [lkvc_pkg::CFG_W-1:0]          capacity_in_use,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                command,
    input logic signed [lkvc_pkg::DATA_W-1:0]  lookup_key,
    input logic signed [lkvc_pkg::DATA_W-1:0]  write_value,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic                                hit,
    input logic signed [lkvc_pkg::DATA_W-1:0]  read_value
);

    // a stalled result stays put
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(read_value))
        else $error("result changed while stalled");

    // a miss always reports all ones
    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> read_value == lkvc_pkg::MISS_VALUE)
        else $error("miss without all-ones value");

    // a fresh result comes only from an accepted get
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && (command == lkvc_pkg::CMD_GET), 2))
        else $error("result without a matching get");

    // requests are only held back by a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("request stalled with result side free");

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (.*);

FILE: sim/tb_lru_key_value_cache_core.sv
`timescale 1ns / 1ps

module tb_lru_key_value_cache_core;

    localparam int ENTRIES         = lkvc_pkg::ENTRIES_DEFAULT;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int KEY_POOL_SIZE   = 16;

    localparam logic [lkvc_pkg::DATA_W-1:0] KEY_MIN       = 32'h8000_0000;
    localparam logic [lkvc_pkg::DATA_W-1:0] KEY_MAX       = 32'h7fff_ffff;
    localparam logic [lkvc_pkg::DATA_W-1:0] KEY_ONES      = 32'hffff_ffff;
    localparam logic [lkvc_pkg::DATA_W-1:0] KEY_LOW       = 32'h0000_0001;
    localparam logic [lkvc_pkg::DATA_W-1:0] KEY_LOW_ALIAS = 32'h8000_0001;
    localparam logic [lkvc_pkg::DATA_W-1:0] KEY_FILL_BASE = 32'h1000_0000;

    typedef struct packed {
        logic                        hit;
        logic [lkvc_pkg::DATA_W-1:0] read_value;
    } read_result_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [lkvc_pkg::CFG_W-1:0]         capacity_in_use = lkvc_pkg::CAPACITY_RESET;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic                               command = lkvc_pkg::CMD_SET;
    logic signed [lkvc_pkg::DATA_W-1:0] lookup_key = '0;
    logic signed [lkvc_pkg::DATA_W-1:0] write_value = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic                               hit;
    logic signed [lkvc_pkg::DATA_W-1:0] read_value;

    // shadow copy of the cache contents and its recency order
    logic                        shadow_valid [ENTRIES];
    logic [lkvc_pkg::DATA_W-1:0] shadow_key [ENTRIES];
    logic [lkvc_pkg::DATA_W-1:0] shadow_value [ENTRIES];
    int                          shadow_rank [ENTRIES];
    int                          shadow_occupancy;
    logic [lkvc_pkg::CFG_W-1:0]  shadow_capacity;

    read_result_t                expected_reads [$];
    logic [lkvc_pkg::DATA_W-1:0] key_pool [KEY_POOL_SIZE];
    int                          failures = 0;
    int                          send_idle_pct = 0;
    int                          stall_pct = 0;
    int                          hold_off_requests = 0;
    int                          quiet_cycles = 0;

    lru_key_value_cache_core u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .capacity_in_use (capacity_in_use),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .lookup_key      (lookup_key),
        .write_value     (write_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .hit             (hit),
        .read_value      (read_value)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic void shadow_reset();
        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_key[i]   = '0;
            shadow_value[i] = '0;
            shadow_rank[i]  = 0;
        end
        shadow_occupancy = 0;
        shadow_capacity  = lkvc_pkg::CAPACITY_RESET;
    endfunction

    function automatic void make_most_recent(int slot);
        int old_rank;
        old_rank = shadow_rank[slot];
        for (int i = 0; i < ENTRIES; i++)
            if (shadow_valid[i] && shadow_rank[i] < old_rank)
                shadow_rank[i]++;
        shadow_rank[slot] = 0;
    endfunction

    function automatic void predict_request(lkvc_pkg::command_t cmd,
                                            logic [lkvc_pkg::DATA_W-1:0] key,
                                            logic [lkvc_pkg::DATA_W-1:0] val);
        int found;
        int free_slot;
        int limit;
        found     = -1;
        free_slot = -1;
        // zero behaves as one, anything above the entry count as the entry count
        limit = (shadow_capacity == 0) ? 1 :
                (int'(shadow_capacity) > ENTRIES) ? ENTRIES : int'(shadow_capacity);
        for (int i = 0; i < ENTRIES; i++)
            if (found < 0 && shadow_valid[i] && shadow_key[i] == key)
                found = i;

        if (cmd == lkvc_pkg::CMD_GET)
        begin
            if (found >= 0)
            begin
                make_most_recent(found);
                expected_reads.push_back(read_result_t'{1'b1, shadow_value[found]});
            end
            else
                expected_reads.push_back(read_result_t'{1'b0, lkvc_pkg::MISS_VALUE});
            return;
        end

        if (found >= 0)
        begin
            shadow_value[found] = val;
            make_most_recent(found);
            return;
        end

        // a full (or over-full after a shrink) store drops everything at rank limit-1 or older
        if (shadow_occupancy >= limit)
            for (int i = 0; i < ENTRIES; i++)
                if (shadow_valid[i] && shadow_rank[i] >= limit - 1)
                begin
                    shadow_valid[i] = 1'b0;
                    shadow_rank[i]  = 0;
                    shadow_occupancy--;
                end

        for (int i = 0; i < ENTRIES; i++)
            if (free_slot < 0 && !shadow_valid[i])
                free_slot = i;
        if (free_slot < 0)
            return;

        for (int i = 0; i < ENTRIES; i++)
            if (shadow_valid[i])
                shadow_rank[i]++;
        shadow_valid[free_slot] = 1'b1;
        shadow_key[free_slot]   = key;
        shadow_value[free_slot] = val;
        shadow_rank[free_slot]  = 0;
        shadow_occupancy++;
    endfunction

    // result side: random stalls, plus a long hold-off whenever one is requested
    initial
    begin : result_receiver
        int hold_off_seen;
        int hold_left;
        hold_off_seen = 0;
        hold_left     = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_requests != hold_off_seen)
            begin
                hold_off_seen = hold_off_requests;
                hold_left     = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        read_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_reads.size() == 0)
            begin
                $error("result with no get waiting: hit %0b read_value %h", hit, read_value);
                failures++;
            end
            else
            begin
                want = expected_reads.pop_front();
                if (hit !== want.hit)
                begin
                    $error("hit: expected %0b, actual %0b", want.hit, hit);
                    failures++;
                end
                if (read_value !== want.read_value)
                begin
                    $error("read_value: expected %h, actual %h", want.read_value, read_value);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("lru_key_value_cache_core test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_request(lkvc_pkg::command_t cmd, logic [lkvc_pkg::DATA_W-1:0] key,
                                logic [lkvc_pkg::DATA_W-1:0] val);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        lookup_key  <= key;
        write_value <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_request(cmd, key, val);
    endtask

    // stop sending, let every get come back and the last set settle
    task automatic wait_until_idle();
        in_valid <= 1'b0;
        while (expected_reads.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(logic [lkvc_pkg::CFG_W-1:0] cap);
        wait_until_idle();
        cfg_valid       <= 1'b1;
        capacity_in_use <= cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid       <= 1'b0;
        shadow_capacity = cap;
    endtask

    task automatic send_random_request();
        lkvc_pkg::command_t          cmd;
        logic [lkvc_pkg::DATA_W-1:0] key;
        cmd = ($urandom_range(0, 99) < 55) ? lkvc_pkg::CMD_GET : lkvc_pkg::CMD_SET;
        if ($urandom_range(0, 99) < 80)
            key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        else
            key = $urandom;
        send_request(cmd, key, $urandom);
    endtask

    task automatic test_set_get_extremes();
        send_request(lkvc_pkg::CMD_GET, KEY_MIN, '0);
        send_request(lkvc_pkg::CMD_SET, KEY_MIN, 32'h7fff_ffff);
        send_request(lkvc_pkg::CMD_SET, KEY_MAX, 32'h8000_0000);
        send_request(lkvc_pkg::CMD_SET, KEY_ONES, 32'h0000_0000);
        send_request(lkvc_pkg::CMD_SET, KEY_LOW, 32'hffff_ffff);
        send_request(lkvc_pkg::CMD_GET, KEY_MIN, 32'hffff_ffff);
        send_request(lkvc_pkg::CMD_GET, KEY_MAX, '0);
        send_request(lkvc_pkg::CMD_GET, KEY_ONES, '0);
        send_request(lkvc_pkg::CMD_SET, KEY_MAX, 32'ha5a5_5a5a);
        send_request(lkvc_pkg::CMD_GET, KEY_MAX, '0);
        // differs from a held key in the top bit only
        send_request(lkvc_pkg::CMD_GET, KEY_LOW_ALIAS, '0);
        // stored all ones must come back with hit set
        send_request(lkvc_pkg::CMD_GET, KEY_LOW, '0);
    endtask

    task automatic test_capacity_clamps();
        // zero acts as one, and the four held entries go on the next new key
        write_capacity(4'd0);
        send_request(lkvc_pkg::CMD_SET, KEY_FILL_BASE, 32'h1111_1111);
        send_request(lkvc_pkg::CMD_SET, KEY_FILL_BASE + 1, 32'h2222_2222);
        send_request(lkvc_pkg::CMD_GET, KEY_FILL_BASE, '0);
        send_request(lkvc_pkg::CMD_GET, KEY_FILL_BASE + 1, '0);
        // fifteen acts as the entry count
        write_capacity(4'd15);
        for (int i = 2; i < ENTRIES + 1; i++)
            send_request(lkvc_pkg::CMD_SET, KEY_FILL_BASE + i, $urandom);
        send_request(lkvc_pkg::CMD_GET, KEY_FILL_BASE + 1, '0);
        send_request(lkvc_pkg::CMD_SET, KEY_FILL_BASE + ENTRIES + 1, $urandom);
        send_request(lkvc_pkg::CMD_GET, KEY_FILL_BASE + 2, '0);
    endtask

    task automatic test_capacity_shrink();
        // entries above the new capacity stay readable until a new key arrives
        write_capacity(4'd2);
        send_request(lkvc_pkg::CMD_GET, KEY_FILL_BASE + 3, '0);
        send_request(lkvc_pkg::CMD_SET, KEY_FILL_BASE + 20, 32'hdead_beef);
        send_request(lkvc_pkg::CMD_GET, KEY_FILL_BASE + 3, '0);
        send_request(lkvc_pkg::CMD_GET, KEY_FILL_BASE + 4, '0);
        send_request(lkvc_pkg::CMD_GET, KEY_FILL_BASE + 20, '0);
    endtask

    task automatic test_result_backpressure();
        write_capacity(lkvc_pkg::CAPACITY_RESET);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_off_requests++;
        for (int i = 0; i < ENTRIES; i++)
            send_request(lkvc_pkg::CMD_SET, key_pool[i], $urandom);
        // gets pile up behind the held result until the input stalls
        repeat (24)
            send_request(lkvc_pkg::CMD_GET, key_pool[$urandom_range(0, ENTRIES + 1)], '0);
        wait_until_idle();
    endtask

    task automatic test_random_traffic(int idle_pct, int stall,
                                       logic [lkvc_pkg::CFG_W-1:0] cap, int count);
        write_capacity(cap);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        repeat (count)
            send_random_request();
    endtask

    initial
    begin
        shadow_reset();
        for (int i = 0; i < KEY_POOL_SIZE; i++)
            key_pool[i] = $urandom;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_set_get_extremes();
        test_capacity_clamps();
        test_capacity_shrink();
        test_result_backpressure();
        test_random_traffic(0, 0, 4'd8, 65);
        test_random_traffic(0, 0, 4'd1, 65);
        test_random_traffic(64, 0, 4'd15, 65);
        test_random_traffic(64, 0, 4'd3, 65);
        test_random_traffic(0, 64, 4'd0, 65);
        test_random_traffic(0, 64, 4'd5, 65);
        test_random_traffic(24, 24, 4'd2, 65);
        test_random_traffic(24, 24, 4'd8, 65);

        wait_until_idle();
        if (failures == 0)
            $display("lru_key_value_cache_core test passed");
        else
            $display("lru_key_value_cache_core test failed");
        $finish;
    end

endmodule

FILE: filelist.f
src/lkvc_pkg.sv
src/lkvc_lookup.sv
src/lru_key_value_cache_core.sv
src/lkvc_checker.sv
sim/tb_lru_key_value_cache_core.sv
